// ===== src/psca_pkg.sv =====
`timescale 1ns / 1ps
package psca_pkg;

  localparam int unsigned MAX_PRIMARIES_DEF = 64;
  localparam int unsigned MAX_CHAINS_DEF    = 1024;
  localparam int unsigned COORD_BITS_DEF    = 24;

  // registers between feeding a primary into the overlap test and its hit flag
  localparam int unsigned TEST_LAT = 5;

  localparam int unsigned MASK_W   = 17;
  localparam int unsigned SCORE_W  = 31;
  localparam int unsigned SEG_W    = 16;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned OIDX_W   = 10;
  localparam int unsigned FCOORD_W = 24;
  localparam int unsigned CIDX_W   = 8;
  localparam int unsigned CDATA_W  = 32;

  localparam logic [MASK_W-1:0] MASK_RESET = 17'd32768;
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  localparam logic [CIDX_W-1:0] CFG_THRESH    = 8'd0;
  localparam logic [CIDX_W-1:0] CFG_HARD_MASK = 8'd1;

  typedef struct packed {
    logic [FCOORD_W-1:0] query_start;
    logic [FCOORD_W-1:0] query_end;
    logic [SCORE_W-1:0]  chain_score;
    logic [SEG_W-1:0]    segment_count;
    logic [SCORE_W-1:0]  prior_sub_score;
    logic                last_in_set;
  } in_item_t;

  typedef struct packed {
    logic [OIDX_W-1:0]  chain_index;
    logic [OIDX_W-1:0]  parent_index;
    logic               is_primary;
    logic [SCORE_W-1:0] parent_sub_score;
    logic [CNT_W-1:0]   parent_sub_count;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] wdata;
  } cfg_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_MERGE,
    ST_TEST,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic drain;
  } sort_ctl_t;

endpackage

// ===== src/psca_if.sv =====
`timescale 1ns / 1ps
interface psca_in_if;
  logic               valid;
  logic               ready;
  psca_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psca_out_if;
  logic                valid;
  logic                ready;
  psca_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface psca_cfg_if;
  logic                valid;
  logic                ready;
  psca_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/psca_ring_cell.sv =====
`timescale 1ns / 1ps
module psca_ring_cell #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         shift,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] q
);

  logic [W-1:0] q_r;

  // take the neighbor's entry on every rotation step
  always_ff @(posedge clk) begin
    if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

// ===== src/psca_sort_cell.sv =====
`timescale 1ns / 1ps
module psca_sort_cell #(
  parameter int unsigned KW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  psca_pkg::sort_ctl_t ctl,
  input  logic [KW-1:0]       x,
  input  logic                left_gt,
  input  logic [KW-1:0]       left_key,
  input  logic                left_vld,
  input  logic [KW-1:0]       right_key,
  input  logic                right_vld,
  output logic [KW-1:0]       key,
  output logic                vld,
  output logic                gt
);

  logic [KW-1:0] key_r;
  logic          vld_r;

  // empty cells sort after everything
  assign gt = !vld_r || (key_r > x);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      priority if (ctl.clr) begin
        vld_r <= 1'b0;
      end else if (ctl.ins && gt) begin
        vld_r <= left_gt ? left_vld : 1'b1;
      end else if (ctl.drain) begin
        vld_r <= right_vld;
      end
    end
  end

  // insert: open a slot by pushing right; drain: pull from the right
  always_ff @(posedge clk) begin
    priority if (ctl.ins && gt) begin
      key_r <= left_gt ? left_key : x;
    end else if (ctl.drain) begin
      key_r <= right_key;
    end
  end

  assign key = key_r;
  assign vld = vld_r;

endmodule

// ===== src/psca_ovl_test.sv =====
`timescale 1ns / 1ps
module psca_ovl_test #(
  parameter int unsigned CB = 24,
  parameter int unsigned IW = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        feed_vld,
  input  logic                        live,
  input  logic [IW-1:0]               feed_idx,
  input  logic [CB-1:0]               sj,
  input  logic [CB-1:0]               ej,
  input  logic [CB-1:0]               si,
  input  logic [CB-1:0]               ei,
  input  logic [CB-1:0]               unc,
  input  logic [psca_pkg::MASK_W-1:0] mask,
  output logic                        hit_vld,
  output logic [IW-1:0]               hit_idx
);

  localparam int unsigned PW = 2 * CB;
  localparam int unsigned LW = PW + 16;
  localparam int unsigned HW = CB + psca_pkg::MASK_W;
  localparam int unsigned W  = PW + 18;

  logic          ov;
  logic [CB-1:0] li, lj, mn, mx, ol, olo, ohi;

  logic          a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r;
  logic [IW-1:0] a_idx_r, b_idx_r, c_idx_r, d_idx_r, e_idx_r;
  logic [CB-1:0] a_mn_r, a_mx_r, a_ol_r;
  logic [PW-1:0] b_olmx_r, b_mnmx_r, b_uncmn_r;
  logic [HW-1:0] c_mlo_r, c_mhi_r;
  logic [LW-1:0] c_lhs_r, c_u_r, d_lhs_r;
  logic [W-1:0]  d_rhs_r;

  always_comb begin
    ov  = live && (ej > sj) && (ej > si) && (sj < ei) && (ei > si);
    li  = ei - si;
    lj  = ej - sj;
    mn  = (lj < li) ? lj : li;
    mx  = (lj > li) ? lj : li;
    ohi = (ei < ej) ? ei : ej;
    olo = (si > sj) ? si : sj;
    ol  = ohi - olo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      a_vld_r <= feed_vld && ov;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r && (W'(d_lhs_r) > d_rhs_r);
    end
  end

  // 65536*ol*max > mask*min*max + 65536*unc*min
  always_ff @(posedge clk) begin
    a_idx_r   <= feed_idx;
    a_mn_r    <= mn;
    a_mx_r    <= mx;
    a_ol_r    <= ol;
    b_idx_r   <= a_idx_r;
    b_olmx_r  <= a_ol_r * a_mx_r;
    b_mnmx_r  <= a_mn_r * a_mx_r;
    b_uncmn_r <= unc * a_mn_r;
    c_idx_r   <= b_idx_r;
    c_mlo_r   <= mask * b_mnmx_r[CB-1:0];
    c_mhi_r   <= mask * b_mnmx_r[PW-1:CB];
    c_lhs_r   <= {b_olmx_r, 16'd0};
    c_u_r     <= {b_uncmn_r, 16'd0};
    d_idx_r   <= c_idx_r;
    d_lhs_r   <= c_lhs_r;
    d_rhs_r   <= (W'(c_mhi_r) << CB) + W'(c_mlo_r) + W'(c_u_r);
    e_idx_r   <= d_idx_r;
  end

  assign hit_vld = e_vld_r;
  assign hit_idx = e_idx_r;

endmodule

// ===== src/primary_secondary_chain_assign.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Payload                                   | Accepted when
// in_if   | in  | start, end, score, segments, prior, last  | valid && ready
// out_if  | out | index, parent, primary, sub-score, count  | valid && ready
// cfg_if  | in  | register index, write data                | valid && ready
// An item goes through three full rotations of the primary ring (clip, test,
// update), one sorted-cell drain and the flush of the overlap test pipeline.
// An item past the chain index limit goes straight from idle to the output step.
// Reset clears counters and state, not the table. The result register lets the
// next item in while a result waits on out_if.ready.
module primary_secondary_chain_assign #(
  parameter int unsigned MAX_PRIMARIES = psca_pkg::MAX_PRIMARIES_DEF,
  parameter int unsigned MAX_CHAINS    = psca_pkg::MAX_CHAINS_DEF,
  parameter int unsigned COORD_BITS    = psca_pkg::COORD_BITS_DEF
) (
  input logic           clk,
  input logic           rst_n,
  psca_in_if.sink       in_if,
  psca_out_if.source    out_if,
  psca_cfg_if.sink      cfg_if
);

  localparam int unsigned NP  = MAX_PRIMARIES;
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned IW  = $clog2(NP);
  localparam int unsigned TW  = $clog2(NP + 1);
  localparam int unsigned CW  = $clog2(MAX_CHAINS);
  localparam int unsigned CCW = $clog2(MAX_CHAINS + 1);
  localparam int unsigned SW  = $clog2(NP + psca_pkg::TEST_LAT + 1);
  localparam int unsigned KW  = 2 * CB;
  localparam int unsigned EW  = 2 * CB + psca_pkg::SCORE_W + psca_pkg::SEG_W
                                + psca_pkg::CNT_W + CW;

  psca_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]                    step_r;
  logic [IW-1:0]                    hk_r;
  logic [TW-1:0]                    total_r;
  logic [CCW-1:0]                   ccnt_r;
  logic [psca_pkg::MASK_W-1:0]      mask_r;
  logic                             hard_r;
  logic [CB-1:0]                    si_r, ei_r, x_r, unc_r;
  logic [psca_pkg::SCORE_W-1:0]     score_r, prior_r, res_sub_r;
  logic [psca_pkg::SEG_W-1:0]       segs_r;
  logic                             last_r, cnt_ovf_r, found_r;
  logic [CW-1:0]                    idx_r, res_cidx_r;
  logic [IW-1:0]                    fidx_r;
  logic [psca_pkg::CNT_W-1:0]       res_cnt_r;
  psca_pkg::out_item_t              out_r, out_nxt;
  logic                             out_vld_r;

  logic in_acc, out_load, rot, live, feed_vld, gen_ov, upd_hit, ins_hit;
  logic hit_vld;
  logic [IW-1:0] hit_idx;
  psca_pkg::sort_ctl_t sctl;

  logic [EW-1:0] ring_q [NP];
  logic [EW-1:0] head_mod;
  logic [CB-1:0] h_start, h_end, cs, ce, mcs, mce;
  logic [psca_pkg::SCORE_W-1:0] h_sub, new_sub;
  logic [psca_pkg::SEG_W-1:0]   h_segs;
  logic [psca_pkg::CNT_W-1:0]   h_cnt, new_cnt;
  logic [CW-1:0]                h_cidx;

  logic [KW-1:0] s_key [NP];
  logic          s_vld [NP];
  logic          s_gt  [NP];

  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == psca_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_load     = (state_r == psca_pkg::ST_OUT) && (!out_vld_r || out_if.ready);
  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_r;

  // primary table: a ring of cells, head at cell 0
  assign {h_start, h_end, h_sub, h_segs, h_cnt, h_cidx} = ring_q[0];

  for (genvar i = 0; i < NP; i++) begin : g_ring
    if (i == NP - 1) begin : g_tail
      psca_ring_cell #(.W(EW)) u_cell (
        .clk(clk), .shift(rot), .d_in(head_mod), .q(ring_q[i])
      );
    end else begin : g_body
      psca_ring_cell #(.W(EW)) u_cell (
        .clk(clk), .shift(rot), .d_in(ring_q[i+1]), .q(ring_q[i])
      );
    end
  end

  // clipped overlaps kept sorted by start, then end
  for (genvar i = 0; i < NP; i++) begin : g_sort
    if (i == 0 && i == NP - 1) begin : g_one
      psca_sort_cell #(.KW(KW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(sctl), .x({cs, ce}),
        .left_gt(1'b0), .left_key('0), .left_vld(1'b0),
        .right_key('0), .right_vld(1'b0),
        .key(s_key[i]), .vld(s_vld[i]), .gt(s_gt[i])
      );
    end else if (i == 0) begin : g_first
      psca_sort_cell #(.KW(KW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(sctl), .x({cs, ce}),
        .left_gt(1'b0), .left_key('0), .left_vld(1'b0),
        .right_key(s_key[i+1]), .right_vld(s_vld[i+1]),
        .key(s_key[i]), .vld(s_vld[i]), .gt(s_gt[i])
      );
    end else if (i == NP - 1) begin : g_last
      psca_sort_cell #(.KW(KW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(sctl), .x({cs, ce}),
        .left_gt(s_gt[i-1]), .left_key(s_key[i-1]), .left_vld(s_vld[i-1]),
        .right_key('0), .right_vld(1'b0),
        .key(s_key[i]), .vld(s_vld[i]), .gt(s_gt[i])
      );
    end else begin : g_mid
      psca_sort_cell #(.KW(KW)) u_cell (
        .clk(clk), .rst_n(rst_n), .ctl(sctl), .x({cs, ce}),
        .left_gt(s_gt[i-1]), .left_key(s_key[i-1]), .left_vld(s_vld[i-1]),
        .right_key(s_key[i+1]), .right_vld(s_vld[i+1]),
        .key(s_key[i]), .vld(s_vld[i]), .gt(s_gt[i])
      );
    end
  end

  psca_ovl_test #(.CB(CB), .IW(IW)) u_test (
    .clk(clk), .rst_n(rst_n), .feed_vld(feed_vld), .live(live), .feed_idx(hk_r),
    .sj(h_start), .ej(h_end), .si(si_r), .ei(ei_r), .unc(unc_r), .mask(mask_r),
    .hit_vld(hit_vld), .hit_idx(hit_idx)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psca_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (ccnt_r >= CCW'(MAX_CHAINS)) ? psca_pkg::ST_OUT : psca_pkg::ST_GEN;
        end
      end
      psca_pkg::ST_GEN: begin
        if (step_r == SW'(NP - 1)) begin
          state_nxt = psca_pkg::ST_MERGE;
        end
      end
      psca_pkg::ST_MERGE: begin
        if (!s_vld[0]) begin
          state_nxt = psca_pkg::ST_TEST;
        end
      end
      psca_pkg::ST_TEST: begin
        if (step_r == SW'(NP + psca_pkg::TEST_LAT)) begin
          state_nxt = psca_pkg::ST_UPDATE;
        end
      end
      psca_pkg::ST_UPDATE: begin
        if (step_r == SW'(NP - 1)) begin
          state_nxt = psca_pkg::ST_OUT;
        end
      end
      psca_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = psca_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psca_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rot      = (state_r == psca_pkg::ST_GEN) || (state_r == psca_pkg::ST_UPDATE)
               || (state_r == psca_pkg::ST_TEST && step_r < SW'(NP));
    feed_vld = (state_r == psca_pkg::ST_TEST) && (step_r < SW'(NP));
    live     = TW'(hk_r) < total_r;
    gen_ov   = live && (h_end > h_start) && (h_end > si_r) && (h_start < ei_r);
    cs       = (h_start < si_r) ? si_r : h_start;
    ce       = (h_end > ei_r) ? ei_r : h_end;
    sctl.clr   = in_acc;
    sctl.ins   = (state_r == psca_pkg::ST_GEN) && gen_ov;
    sctl.drain = (state_r == psca_pkg::ST_MERGE) && s_vld[0];
    mcs      = s_key[0][KW-1:CB];
    mce      = s_key[0][CB-1:0];
    upd_hit  = found_r && (hk_r == fidx_r);
    ins_hit  = !found_r && (TW'(hk_r) == total_r);
    new_sub  = (score_r > h_sub) ? score_r : h_sub;
    new_cnt  = (segs_r >= h_segs && h_cnt != psca_pkg::CNT_MAX) ? h_cnt + 1'b1 : h_cnt;
    head_mod = ring_q[0];
    if (state_r == psca_pkg::ST_UPDATE) begin
      priority if (upd_hit) begin
        head_mod = {h_start, h_end, new_sub, h_segs, new_cnt, h_cidx};
      end else if (ins_hit) begin
        head_mod = {si_r, ei_r, prior_r, segs_r, psca_pkg::CNT_W'(0), idx_r};
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    if (cnt_ovf_r) begin
      out_nxt.overflow = 1'b1;
    end else begin
      out_nxt.chain_index = psca_pkg::OIDX_W'(idx_r);
      if (found_r) begin
        out_nxt.parent_index     = psca_pkg::OIDX_W'(res_cidx_r);
        out_nxt.parent_sub_score = res_sub_r;
        out_nxt.parent_sub_count = res_cnt_r;
      end else begin
        out_nxt.parent_index     = psca_pkg::OIDX_W'(idx_r);
        out_nxt.is_primary       = 1'b1;
        out_nxt.parent_sub_score = prior_r;
        out_nxt.overflow         = (total_r == TW'(NP));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= psca_pkg::ST_IDLE;
      step_r    <= '0;
      hk_r      <= '0;
      total_r   <= '0;
      ccnt_r    <= '0;
      mask_r    <= psca_pkg::MASK_RESET;
      hard_r    <= 1'b0;
      found_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_nxt != state_r) ? '0 : step_r + 1'b1;
      if (rot) begin
        hk_r <= (hk_r == IW'(NP - 1)) ? '0 : hk_r + 1'b1;
      end
      if (cfg_if.valid) begin
        if (cfg_if.data.index == psca_pkg::CFG_THRESH) begin
          mask_r <= cfg_if.data.wdata[psca_pkg::MASK_W-1:0];
        end else if (cfg_if.data.index == psca_pkg::CFG_HARD_MASK) begin
          hard_r <= cfg_if.data.wdata[0];
        end
      end
      if (in_acc) begin
        found_r <= 1'b0;
      end else if (state_r == psca_pkg::ST_TEST && hit_vld && !found_r) begin
        found_r <= 1'b1;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
        if (last_r) begin
          total_r <= '0;
          ccnt_r  <= '0;
        end else if (!cnt_ovf_r) begin
          ccnt_r <= ccnt_r + 1'b1;
          if (!found_r && total_r < TW'(NP)) begin
            total_r <= total_r + 1'b1;
          end
        end
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      si_r      <= CB'(in_if.data.query_start);
      ei_r      <= CB'(in_if.data.query_end);
      x_r       <= CB'(in_if.data.query_start);
      unc_r     <= '0;
      score_r   <= in_if.data.chain_score;
      segs_r    <= in_if.data.segment_count;
      prior_r   <= in_if.data.prior_sub_score;
      last_r    <= in_if.data.last_in_set;
      cnt_ovf_r <= ccnt_r >= CCW'(MAX_CHAINS);
      idx_r     <= ccnt_r[CW-1:0];
    end
    // sweep the sorted overlaps, summing uncovered gaps; hard mask mode zeroes the sum
    if (state_r == psca_pkg::ST_MERGE) begin
      if (s_vld[0]) begin
        if (mcs > x_r) begin
          unc_r <= unc_r + (mcs - x_r);
        end
        if (mce > x_r) begin
          x_r <= mce;
        end
      end else if (hard_r) begin
        unc_r <= '0;
      end else if (ei_r > x_r) begin
        unc_r <= unc_r + (ei_r - x_r);
      end
    end
    if (state_r == psca_pkg::ST_TEST && hit_vld && !found_r) begin
      fidx_r <= hit_idx;
    end
    if (state_r == psca_pkg::ST_UPDATE && upd_hit) begin
      res_sub_r  <= new_sub;
      res_cnt_r  <= new_cnt;
      res_cidx_r <= h_cidx;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTH
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(NP)) else $error("primary count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != psca_pkg::ST_IDLE) else $error("accepted item not started");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == psca_pkg::ST_OUT)
    else $error("result raised outside output step");

  a_sort_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psca_pkg::ST_TEST && step_r == '0) |-> !s_vld[NP-1])
    else $error("overlap list not drained before test");
`endif

endmodule
